// File: rtl/bsc_pkg.sv
// Shared types, sizes and codes for the banker's safety check block.
// Used by bsc_cell, bsc_ctrl and bankers_safety_check; depends on nothing.

package bsc_pkg;

	// Sizing
	localparam int PROCS      = 8;
	localparam int RES        = 4;
	localparam int COUNT_BITS = 8;

	localparam int PIDX_W    = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int RIDX_W    = (RES > 1) ? $clog2(RES) : 1;
	localparam int CNT_W     = $clog2(PROCS + 1);
	localparam int NR_W      = $clog2(RES + 1);
	localparam int WORK_BITS = COUNT_BITS + $clog2(PROCS + 1);

	// Fixed field widths of the transaction formats
	localparam int PROC_FIELD_W = 3;
	localparam int RES_FIELD_W  = 2;
	localparam int VALUE_W      = 8;
	localparam int AP_W         = 4;
	localparam int AR_W         = 3;
	localparam int CFG_DATA_W   = 4;

	// Configuration register indexes
	localparam logic CFG_ACTIVE_PROCESSES = 1'b0;
	localparam logic CFG_ACTIVE_RESOURCES = 1'b1;

	// Result kinds
	localparam logic KIND_SAFE     = 1'b0;
	localparam logic KIND_DEADLOCK = 1'b1;

	typedef enum logic [1:0] {
		CMD_WR_ALLOC = 2'd0,
		CMD_WR_MAX   = 2'd1,
		CMD_WR_AVAIL = 2'd2,
		CMD_EVAL     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic [PROC_FIELD_W-1:0] process;
		logic [RES_FIELD_W-1:0]  resource;
		logic [VALUE_W-1:0]      value;
	} in_item_t;

	typedef struct packed {
		logic                    kind;
		logic [PROC_FIELD_W-1:0] process_id;
		logic                    last;
	} out_item_t;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [WORK_BITS-1:0]  work_t;

	// Work token walking the cell chain
	typedef struct packed {
		logic                          valid;
		logic                          progress;
		logic [CNT_W-1:0]              done;
		logic [RES-1:0][WORK_BITS-1:0] work;
	} tok_t;

	// Table write broadcast to the cells
	typedef struct packed {
		logic              en;
		logic              sel_max;
		logic [PIDX_W-1:0] process;
		logic [RIDX_W-1:0] resource;
		count_t            value;
	} wr_t;

	// Per-cell status seen by the controller
	typedef struct packed {
		logic             finished;
		logic [CNT_W-1:0] rank;
	} cell_stat_t;

endpackage

// File: rtl/bsc_cell.sv
// One process cell of the safety check chain: holds the allocation and maximum rows,
// the finished flag and the finish rank. Depends on bsc_pkg.

module bsc_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [bsc_pkg::PIDX_W-1:0] cell_idx,
	input  logic [bsc_pkg::CNT_W-1:0]  np,
	input  logic [bsc_pkg::NR_W-1:0]   nr,
	input  bsc_pkg::wr_t             wr,
	input  logic                     clr,
	input  bsc_pkg::tok_t            tok_in,
	output bsc_pkg::tok_t            tok_out,
	output bsc_pkg::cell_stat_t      stat
);

	bsc_pkg::count_t                 alloc_q [bsc_pkg::RES];
	bsc_pkg::count_t                 max_q [bsc_pkg::RES];
	logic                            fin_q;
	logic [bsc_pkg::CNT_W-1:0]       rank_q;
	bsc_pkg::tok_t                   tok_q;

	logic                            eff_fin;
	logic                            active;
	logic                            fits;
	logic                            fire;
	logic [bsc_pkg::WORK_BITS:0]     reach;
	bsc_pkg::tok_t                   tok_nxt;

	// Check need against work on every active resource, then claim or pass the token
	always_comb begin
		eff_fin = fin_q && !clr;
		active  = bsc_pkg::CNT_W'(cell_idx) < np;
		fits    = 1'b1;
		reach   = '0;
		for (int r = 0; r < bsc_pkg::RES; r++) begin
			reach = (bsc_pkg::WORK_BITS + 1)'(tok_in.work[r])
				+ (bsc_pkg::WORK_BITS + 1)'(alloc_q[r]);
			if ((bsc_pkg::NR_W'(r) < nr) && (reach < (bsc_pkg::WORK_BITS + 1)'(max_q[r]))) begin
				fits = 1'b0;
			end
		end
		fire    = tok_in.valid && active && !eff_fin && fits;
		tok_nxt = tok_in;
		if (fire) begin
			for (int r = 0; r < bsc_pkg::RES; r++) begin
				tok_nxt.work[r] = tok_in.work[r] + bsc_pkg::WORK_BITS'(alloc_q[r]);
			end
			tok_nxt.done     = tok_in.done + bsc_pkg::CNT_W'(1);
			tok_nxt.progress = 1'b1;
		end
	end

	// Advance the token, track finish, take table writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			fin_q <= 1'b0;
			for (int r = 0; r < bsc_pkg::RES; r++) begin
				alloc_q[r] <= '0;
				max_q[r]   <= '0;
			end
		end else begin
			tok_q <= tok_nxt;
			if (fire) begin
				fin_q <= 1'b1;
			end else if (clr) begin
				fin_q <= 1'b0;
			end
			if (wr.en && (wr.process == cell_idx)) begin
				if (wr.sel_max) begin
					max_q[wr.resource] <= wr.value;
				end else begin
					alloc_q[wr.resource] <= wr.value;
				end
			end
		end
	end

	// Record position in the safe sequence
	always_ff @(posedge clk) begin
		if (fire) begin
			rank_q <= tok_in.done;
		end
	end

	assign tok_out       = tok_q;
	assign stat.finished = fin_q;
	assign stat.rank     = rank_q;

endmodule

// File: rtl/bsc_ctrl.sv
// Controller of the safety check: configuration, available vector, transaction
// decode, pass sequencing and result emission. Depends on bsc_pkg.

module bsc_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [bsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  bsc_pkg::in_item_t                 in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output bsc_pkg::out_item_t                out_item,
	output bsc_pkg::wr_t                      wr,
	output logic                              clr,
	output bsc_pkg::tok_t                     inj,
	input  bsc_pkg::tok_t                     ret,
	input  bsc_pkg::cell_stat_t               stat [bsc_pkg::PROCS],
	output logic [bsc_pkg::CNT_W-1:0]         np,
	output logic [bsc_pkg::NR_W-1:0]          nr
);

	bsc_pkg::state_t               state_q;
	bsc_pkg::state_t               state_nxt;
	logic [bsc_pkg::AP_W-1:0]      ap_q;
	logic [bsc_pkg::AR_W-1:0]      ar_q;
	bsc_pkg::count_t               avail_q [bsc_pkg::RES];
	logic                          mode_q;
	logic [bsc_pkg::CNT_W-1:0]     k_q;
	logic                          out_valid_q;
	bsc_pkg::out_item_t            out_item_q;

	logic                          proc_ok;
	logic                          res_ok;
	logic                          avail_we;
	logic                          run_end;
	logic                          slot;
	logic                          emit_now;
	logic                          k_step;
	logic [bsc_pkg::PIDX_W-1:0]    sid;
	logic [bsc_pkg::PROCS-1:0]     ua;
	logic                          any_above;
	logic                          cur_ua;
	bsc_pkg::out_item_t            res;

	// Clamp the active counts into range
	always_comb begin
		if (ap_q == '0) begin
			np = bsc_pkg::CNT_W'(1);
		end else if (int'(ap_q) > bsc_pkg::PROCS) begin
			np = bsc_pkg::CNT_W'(bsc_pkg::PROCS);
		end else begin
			np = bsc_pkg::CNT_W'(ap_q);
		end
		if (ar_q == '0) begin
			nr = bsc_pkg::NR_W'(1);
		end else if (int'(ar_q) > bsc_pkg::RES) begin
			nr = bsc_pkg::NR_W'(bsc_pkg::RES);
		end else begin
			nr = bsc_pkg::NR_W'(ar_q);
		end
	end

	// Build the next result from cell status
	always_comb begin
		sid       = '0;
		ua        = '0;
		any_above = 1'b0;
		for (int i = 0; i < bsc_pkg::PROCS; i++) begin
			if (stat[i].finished && (stat[i].rank == k_q)) begin
				sid = bsc_pkg::PIDX_W'(i);
			end
			ua[i] = !stat[i].finished && (bsc_pkg::CNT_W'(i) < np);
			if (ua[i] && (bsc_pkg::CNT_W'(i) > k_q)) begin
				any_above = 1'b1;
			end
		end
		cur_ua = ua[k_q[bsc_pkg::PIDX_W-1:0]];
		res.kind = mode_q;
		if (mode_q == bsc_pkg::KIND_SAFE) begin
			res.process_id = bsc_pkg::PROC_FIELD_W'(sid);
			res.last       = (bsc_pkg::CNT_W'(k_q + bsc_pkg::CNT_W'(1)) == np);
		end else begin
			res.process_id = bsc_pkg::PROC_FIELD_W'(k_q);
			res.last       = !any_above;
		end
	end

	assign proc_ok = int'(in_item.process) < bsc_pkg::PROCS;
	assign res_ok  = int'(in_item.resource) < bsc_pkg::RES;
	assign run_end = ret.valid && ((ret.done == np) || !ret.progress);
	assign slot    = !out_valid_q || !out_stall;

	// Drive handshake, table writes, token injection and emission
	always_comb begin
		in_stall    = 1'b1;
		clr         = 1'b0;
		inj         = '0;
		wr          = '0;
		avail_we    = 1'b0;
		emit_now    = 1'b0;
		k_step      = 1'b0;
		wr.process  = bsc_pkg::PIDX_W'(in_item.process);
		wr.resource = bsc_pkg::RIDX_W'(in_item.resource);
		wr.value    = bsc_pkg::COUNT_BITS'(in_item.value);
		wr.sel_max  = (in_item.cmd == bsc_pkg::CMD_WR_MAX);
		unique case (state_q)
			bsc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (in_item.cmd)
						bsc_pkg::CMD_EVAL: begin
							clr       = 1'b1;
							inj.valid = 1'b1;
							for (int r = 0; r < bsc_pkg::RES; r++) begin
								inj.work[r] = bsc_pkg::WORK_BITS'(avail_q[r]);
							end
						end
						bsc_pkg::CMD_WR_AVAIL: begin
							avail_we = res_ok;
						end
						bsc_pkg::CMD_WR_ALLOC, bsc_pkg::CMD_WR_MAX: begin
							wr.en = proc_ok && res_ok;
						end
						default: begin
							wr.en = 1'b0;
						end
					endcase
				end
			end
			bsc_pkg::ST_RUN: begin
				if (ret.valid && !run_end) begin
					inj          = ret;
					inj.progress = 1'b0;
				end
			end
			bsc_pkg::ST_EMIT: begin
				if (slot) begin
					k_step   = 1'b1;
					emit_now = (mode_q == bsc_pkg::KIND_SAFE) || cur_ua;
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Sequence idle, evaluation passes and emission
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bsc_pkg::ST_IDLE: begin
				if (in_valid && (in_item.cmd == bsc_pkg::CMD_EVAL)) begin
					state_nxt = bsc_pkg::ST_RUN;
				end
			end
			bsc_pkg::ST_RUN: begin
				if (run_end) begin
					state_nxt = bsc_pkg::ST_EMIT;
				end
			end
			bsc_pkg::ST_EMIT: begin
				if (emit_now && res.last) begin
					state_nxt = bsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bsc_pkg::ST_IDLE;
			end
		endcase
	end

	// Hold control state, configuration and the available vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsc_pkg::ST_IDLE;
			ap_q        <= bsc_pkg::AP_W'(bsc_pkg::PROCS);
			ar_q        <= bsc_pkg::AR_W'(bsc_pkg::RES);
			mode_q      <= bsc_pkg::KIND_SAFE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < bsc_pkg::RES; r++) begin
				avail_q[r] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_index)
					bsc_pkg::CFG_ACTIVE_PROCESSES: ap_q <= bsc_pkg::AP_W'(cfg_data);
					bsc_pkg::CFG_ACTIVE_RESOURCES: ar_q <= bsc_pkg::AR_W'(cfg_data);
					default: ap_q <= ap_q;
				endcase
			end
			if (avail_we) begin
				avail_q[bsc_pkg::RIDX_W'(in_item.resource)] <= bsc_pkg::COUNT_BITS'(in_item.value);
			end
			if ((state_q == bsc_pkg::ST_RUN) && run_end) begin
				mode_q <= (ret.done == np) ? bsc_pkg::KIND_SAFE : bsc_pkg::KIND_DEADLOCK;
				k_q    <= '0;
			end else if (k_step) begin
				k_q <= k_q + bsc_pkg::CNT_W'(1);
			end
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (emit_now) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// File: rtl/bankers_safety_check.sv
// Top level of the banker's safety check: a chain of process cells and its controller.
// Depends on bsc_pkg, bsc_cell and bsc_ctrl.

// A load transaction (allocation, maximum or available write) is taken while idle and
// yields no result. An evaluate transaction holds the input stalled while a work token
// walks the chain of PROCS cells, one cell per cycle; a run takes 1 to active_processes
// passes of the chain. The safe sequence results then leave one per cycle when the
// output is not stalled, active_processes of them; a deadlock report gives one result
// for each unfinished active process. Loads accepted after the last result is
// registered overlap its delivery. All tables clear at reset; no clearing pass.

module bankers_safety_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bsc_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bsc_pkg::out_item_t             out_item
);

	bsc_pkg::tok_t               tok [bsc_pkg::PROCS + 1];
	bsc_pkg::cell_stat_t         stat [bsc_pkg::PROCS];
	bsc_pkg::wr_t                wr;
	logic                        clr;
	logic [bsc_pkg::CNT_W-1:0]   np;
	logic [bsc_pkg::NR_W-1:0]    nr;

	bsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.wr        (wr),
		.clr       (clr),
		.inj       (tok[0]),
		.ret       (tok[bsc_pkg::PROCS]),
		.stat      (stat),
		.np        (np),
		.nr        (nr)
	);

	// Chain the process cells in index order
	for (genvar i = 0; i < bsc_pkg::PROCS; i++) begin : g_cell
		bsc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (bsc_pkg::PIDX_W'(i)),
			.np       (np),
			.nr       (nr),
			.wr       (wr),
			.clr      (clr),
			.tok_in   (tok[i]),
			.tok_out  (tok[i + 1]),
			.stat     (stat[i])
		);
	end

endmodule
